// ----- hw/rtl/xmkb_pkg.sv -----
// Package for the XOR-metric k-bucket routing table.
// Holds payload structs, status and request codes, sequencer states and defaults.
// No dependencies.
`default_nettype none

package xmkb_pkg;

  localparam int ID_BYTES_DEF    = 8;
  localparam int BUCKET_SIZE_DEF = 8;
  localparam int K_BEST          = 8;
  localparam int KW              = $clog2(K_BEST + 1);
  localparam int KIW             = $clog2(K_BEST);

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] node_key;
    logic        head_responded;
  } xmkb_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [63:0] result_id;
    logic [63:0] result_distance;
    logic        last;
  } xmkb_out_t;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_PING   = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_NONE   = 2'd3
  } xmkb_req_t;

  typedef enum logic [3:0] {
    STS_MOVED     = 4'd0,
    STS_ADDED     = 4'd1,
    STS_PING_HEAD = 4'd2,
    STS_SELF      = 4'd3,
    STS_EVICT_ADD = 4'd4,
    STS_HEAD_KEPT = 4'd5,
    STS_FOUND     = 4'd6,
    STS_EMPTY     = 4'd7,
    STS_BUSY      = 4'd8,
    STS_NO_PEND   = 4'd9
  } xmkb_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEC,
    S_UFILL,
    S_URD,
    S_UCHK,
    S_UADD,
    S_PFILL,
    S_PHEAD,
    S_SHRD,
    S_SHWR,
    S_SHTAIL,
    S_FFILL,
    S_FWAIT,
    S_FENT,
    S_FEND,
    S_FOUT,
    S_EMIT
  } xmkb_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/xmkb_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the bucket store and the bucket fill counts. No dependencies.
`default_nettype none

module xmkb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/xor_metric_kbucket_table.sv -----
// Usage notes for xor_metric_kbucket_table.
// Input channel in_valid/in_ready/in_data carries update, ping outcome and find
// requests; output channel out_valid/out_ready/out_data returns results, with
// last set on the final result of each request. cfg_we/cfg_wdata write self_id.
// One request is handled at a time; in_ready is high while the sequencer idles,
// also while a result still waits in the output register.
// Work is paced by the single read port of the bucket store RAM: the update
// match scan and the entry shift of update and ping outcome read one entry at
// a time; find sweeps every bucket, then returns one result per cycle (up to 8)
// while the receiver takes them.
// Reset clears fill valid bits, the pending ping and the output valid flag; the
// bucket store needs no clearing, as only entries below a fill count are read.
// A stalled receiver holds the output register; the sequencer waits at its
// emit step until the register is free.
`default_nettype none

module xor_metric_kbucket_table
  import xmkb_pkg::*;
#(
  parameter int ID_BYTES    = ID_BYTES_DEF,
  parameter int BUCKET_SIZE = BUCKET_SIZE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire xmkb_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output xmkb_out_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [63:0] cfg_wdata
);

  localparam int IDW    = 8 * ID_BYTES;
  localparam int NUM_B  = IDW;
  localparam int BW     = $clog2(NUM_B);
  localparam int IW     = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
  localparam int FW     = $clog2(BUCKET_SIZE + 1);
  localparam int SDEPTH = NUM_B * (1 << IW);
  localparam int SAW    = BW + IW;
  localparam logic [FW-1:0] BS_F   = FW'(BUCKET_SIZE);
  localparam logic [BW-1:0] LAST_B = BW'(NUM_B - 1);
  localparam logic [KW-1:0] K_F    = KW'(K_BEST);

  // Registers
  xmkb_state_t     state_r, state_nxt;
  logic [IDW-1:0]  self_r;
  logic [IDW-1:0]  key_r, key_nxt;
  xmkb_req_t       type_r, type_nxt;
  logic            resp_r, resp_nxt;
  logic [BW-1:0]   b_r, b_nxt;
  logic [FW-1:0]   n_r, n_nxt;
  logic [FW-1:0]   i_r, i_nxt;
  logic [IDW-1:0]  head_r, head_nxt;
  logic [IDW-1:0]  val_r, val_nxt;
  xmkb_status_t    sts_r, sts_nxt;
  logic            pend_r, pend_nxt;
  logic [IDW-1:0]  pnew_r, pnew_nxt;
  logic [BW-1:0]   pb_r, pb_nxt;
  logic [KW-1:0]   cnt_r, cnt_nxt;
  logic [IDW-1:0]  best_id_r [K_BEST];
  logic [IDW-1:0]  best_id_nxt [K_BEST];
  logic [IDW-1:0]  best_dist_r [K_BEST];
  logic [IDW-1:0]  best_dist_nxt [K_BEST];
  logic            rv_r, rv_nxt;
  xmkb_out_t       res_r, res_nxt;
  logic [KW-1:0]   eix_r, eix_nxt;
  xmkb_out_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            fv_r, fv_nxt;
  logic [NUM_B-1:0] fvalid_r, fvalid_nxt;

  // Memory ports
  logic            st_we;
  logic [SAW-1:0]  st_waddr, st_raddr;
  logic [IDW-1:0]  st_wdata, st_rdata;
  logic            fl_we;
  logic [BW-1:0]   fl_waddr, fl_raddr;
  logic [FW-1:0]   fl_wdata, fl_rdata;

  // Working values
  logic [IDW-1:0]  dist_self;
  logic [BW-1:0]   top;
  logic [FW-1:0]   fill_q;
  logic [FW-1:0]   i_inc;
  logic [FW-1:0]   n_dec;
  logic            slot;
  logic [IDW-1:0]  cand_d;
  logic [K_BEST-1:0] place;

  xmkb_ram #(.WIDTH(IDW), .DEPTH(SDEPTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  xmkb_ram #(.WIDTH(FW), .DEPTH(NUM_B)) u_fill (
    .clk   (clk),
    .we    (fl_we),
    .waddr (fl_waddr),
    .wdata (fl_wdata),
    .raddr (fl_raddr),
    .rdata (fl_rdata)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dist_self = key_r ^ self_r;
  assign fill_q    = fv_r ? fl_rdata : '0;
  assign i_inc     = i_r + 1'b1;
  assign n_dec     = n_r - 1'b1;
  assign slot      = !out_valid_r || out_ready;
  assign cand_d    = st_rdata ^ key_r;

  // Bucket index: highest set bit of the distance to self
  always_comb begin
    top = '0;
    for (int j = 0; j < IDW; j++) begin
      if (dist_self[j]) begin
        top = BW'(j);
      end
    end
  end

  // Insertion points of the running nearest list
  always_comb begin
    for (int j = 0; j < K_BEST; j++) begin
      place[j] = (KW'(j) >= cnt_r) || (best_dist_r[j] > cand_d);
    end
  end

  // Sequencer: next state, memory accesses and result staging
  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    type_nxt      = type_r;
    resp_nxt      = resp_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    head_nxt      = head_r;
    val_nxt       = val_r;
    sts_nxt       = sts_r;
    pend_nxt      = pend_r;
    pnew_nxt      = pnew_r;
    pb_nxt        = pb_r;
    cnt_nxt       = cnt_r;
    best_id_nxt   = best_id_r;
    best_dist_nxt = best_dist_r;
    rv_nxt        = 1'b0;
    res_nxt       = res_r;
    eix_nxt       = eix_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fv_nxt        = fv_r;
    fvalid_nxt    = fvalid_r;
    st_we         = 1'b0;
    st_waddr      = {b_r, i_r[IW-1:0]};
    st_wdata      = key_r;
    st_raddr      = {b_r, i_r[IW-1:0]};
    fl_we         = 1'b0;
    fl_waddr      = b_r;
    fl_wdata      = n_r;
    fl_raddr      = b_r;

    // Fold a scanned entry into the nearest list
    if (rv_r) begin
      for (int j = 0; j < K_BEST; j++) begin
        if (place[j]) begin
          if (j == 0 || !place[(j > 0) ? j - 1 : 0]) begin
            best_id_nxt[j]   = st_rdata;
            best_dist_nxt[j] = cand_d;
          end else begin
            best_id_nxt[j]   = best_id_r[(j > 0) ? j - 1 : 0];
            best_dist_nxt[j] = best_dist_r[(j > 0) ? j - 1 : 0];
          end
        end
      end
      if (cnt_r < K_F) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_data.node_key[IDW-1:0];
          type_nxt  = xmkb_req_t'(in_data.req_type);
          resp_nxt  = in_data.head_responded;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        case (type_r)
          REQ_UPDATE: begin
            if (dist_self == '0) begin
              res_nxt   = '{STS_SELF, 64'(key_r), 64'd0, 1'b1};
              state_nxt = S_EMIT;
            end else if (pend_r) begin
              res_nxt   = '{STS_BUSY, 64'(key_r), 64'd0, 1'b1};
              state_nxt = S_EMIT;
            end else begin
              b_nxt     = top;
              fl_raddr  = top;
              fv_nxt    = fvalid_r[top];
              state_nxt = S_UFILL;
            end
          end
          REQ_PING: begin
            if (!pend_r) begin
              res_nxt   = '{STS_NO_PEND, 64'd0, 64'd0, 1'b1};
              state_nxt = S_EMIT;
            end else begin
              b_nxt     = pb_r;
              fl_raddr  = pb_r;
              fv_nxt    = fvalid_r[pb_r];
              state_nxt = S_PFILL;
            end
          end
          REQ_FIND: begin
            b_nxt     = '0;
            cnt_nxt   = '0;
            state_nxt = S_FFILL;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Update: look for the node in its bucket
      S_UFILL: begin
        n_nxt     = fill_q;
        i_nxt     = '0;
        state_nxt = (fill_q == '0) ? S_UADD : S_URD;
      end

      S_URD: begin
        state_nxt = S_UCHK;
      end

      S_UCHK: begin
        if (i_r == '0) begin
          head_nxt = st_rdata;
        end
        if (st_rdata == key_r) begin
          val_nxt   = key_r;
          sts_nxt   = STS_MOVED;
          state_nxt = S_SHRD;
        end else begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == n_r) ? S_UADD : S_URD;
        end
      end

      S_UADD: begin
        if (n_r < BS_F) begin
          st_we       = 1'b1;
          st_waddr    = {b_r, n_r[IW-1:0]};
          st_wdata    = key_r;
          fl_we       = 1'b1;
          fl_wdata    = n_r + 1'b1;
          fvalid_nxt[b_r] = 1'b1;
          res_nxt     = '{STS_ADDED, 64'(key_r), 64'd0, 1'b1};
        end else begin
          pend_nxt    = 1'b1;
          pnew_nxt    = key_r;
          pb_nxt      = b_r;
          res_nxt     = '{STS_PING_HEAD, 64'(head_r), 64'd0, 1'b1};
        end
        state_nxt = S_EMIT;
      end

      // Ping outcome: fetch the head of the waiting bucket
      S_PFILL: begin
        if (fill_q == '0) begin
          pend_nxt  = 1'b0;
          res_nxt   = '{STS_NO_PEND, 64'd0, 64'd0, 1'b1};
          state_nxt = S_EMIT;
        end else begin
          st_raddr  = {b_r, {IW{1'b0}}};
          n_nxt     = fill_q;
          i_nxt     = '0;
          state_nxt = S_PHEAD;
        end
      end

      S_PHEAD: begin
        head_nxt  = st_rdata;
        pend_nxt  = 1'b0;
        val_nxt   = resp_r ? st_rdata : pnew_r;
        sts_nxt   = resp_r ? STS_HEAD_KEPT : STS_EVICT_ADD;
        state_nxt = S_SHRD;
      end

      // Close the gap at i and put the value at the tail
      S_SHRD: begin
        st_raddr = {b_r, i_inc[IW-1:0]};
        if (i_inc < n_r) begin
          state_nxt = S_SHWR;
        end else begin
          state_nxt = S_SHTAIL;
        end
      end

      S_SHWR: begin
        st_we     = 1'b1;
        st_wdata  = st_rdata;
        i_nxt     = i_inc;
        state_nxt = S_SHRD;
      end

      S_SHTAIL: begin
        st_we     = 1'b1;
        st_waddr  = {b_r, n_dec[IW-1:0]};
        st_wdata  = val_r;
        res_nxt   = '{sts_r, (sts_r == STS_MOVED) ? 64'(key_r) : 64'(head_r),
                      64'd0, 1'b1};
        state_nxt = S_EMIT;
      end

      // Find: sweep every bucket, entries streamed one per cycle
      S_FFILL: begin
        fv_nxt    = fvalid_r[b_r];
        state_nxt = S_FWAIT;
      end

      S_FWAIT: begin
        n_nxt = fill_q;
        i_nxt = '0;
        if (fill_q != '0) begin
          state_nxt = S_FENT;
        end else if (b_r == LAST_B) begin
          state_nxt = S_FEND;
        end else begin
          b_nxt     = b_r + 1'b1;
          state_nxt = S_FFILL;
        end
      end

      S_FENT: begin
        if (i_r < n_r) begin
          rv_nxt = 1'b1;
          i_nxt  = i_inc;
        end else if (b_r == LAST_B) begin
          state_nxt = S_FEND;
        end else begin
          b_nxt     = b_r + 1'b1;
          state_nxt = S_FFILL;
        end
      end

      S_FEND: begin
        eix_nxt = '0;
        if (cnt_r == '0) begin
          res_nxt   = '{STS_EMPTY, 64'd0, 64'd0, 1'b1};
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FOUT;
        end
      end

      S_FOUT: begin
        if (slot) begin
          out_nxt       = '{STS_FOUND, 64'(best_id_r[eix_r[KIW-1:0]]),
                            64'(best_dist_r[eix_r[KIW-1:0]]),
                            (eix_r + 1'b1) == cnt_r};
          out_valid_nxt = 1'b1;
          eix_nxt       = eix_r + 1'b1;
          if ((eix_r + 1'b1) == cnt_r) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (slot) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      self_r      <= '0;
      pend_r      <= 1'b0;
      pnew_r      <= '0;
      pb_r        <= '0;
      fvalid_r    <= '0;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
      fv_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        self_r <= cfg_wdata[IDW-1:0];
      end
      pend_r      <= pend_nxt;
      pnew_r      <= pnew_nxt;
      pb_r        <= pb_nxt;
      fvalid_r    <= fvalid_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r        <= rv_nxt;
      fv_r        <= fv_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    type_r      <= type_nxt;
    resp_r      <= resp_nxt;
    b_r         <= b_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    head_r      <= head_nxt;
    val_r       <= val_nxt;
    sts_r       <= sts_nxt;
    best_id_r   <= best_id_nxt;
    best_dist_r <= best_dist_nxt;
    res_r       <= res_nxt;
    eix_r       <= eix_nxt;
    out_r       <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= K_F) else $error("nearest list count beyond K");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FOUT && cnt_r >= 2) |-> best_dist_r[0] <= best_dist_r[1])
    else $error("nearest list out of order");

  a_head_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PHEAD) |-> pend_r) else $error("ping outcome without pending ping");

  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHRD) |-> (i_r < n_r)) else $error("shift index past bucket fill");
`endif

endmodule

`default_nettype wire
